>>> rtl/core/ebml_pkg.sv
// Shared types, codes and helpers for the EBML element header parser.
package ebml_pkg;

  typedef enum logic [1:0] {
    PH_ID_LEAD   = 2'd0,
    PH_ID_REST   = 2'd1,
    PH_SIZE_LEAD = 2'd2,
    PH_SIZE_REST = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam int unsigned OffsetW = 63;
  localparam int unsigned SizeW   = 56;
  localparam int unsigned IdW     = 32;

  typedef struct packed {
    logic [7:0]         stream_byte;
    logic [OffsetW-1:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [IdW-1:0]     element_id;
    logic [2:0]         id_length;
    logic [SizeW-1:0]   size_value;
    logic [3:0]         size_length;
    logic [OffsetW-1:0] header_start;
    logic [OffsetW-1:0] element_end;
    status_t            status;
  } result_t;

  // Count leading zeros of a byte, 8 for a zero byte.
  function automatic logic [3:0] lead_zeros(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/ebml_in_stage.sv
// Input register stage: holds one header byte and its offset for the parser.
module ebml_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebml_pkg::in_word_t in_word,
  input  logic               take,
  output logic               word_valid,
  output ebml_pkg::in_word_t word
);

  logic               valid_r, valid_nxt;
  ebml_pkg::in_word_t word_r;

  assign in_ready   = !valid_r || take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) word_r <= in_word;
  end

endmodule

>>> rtl/core/ebml_parse.sv
// Header state machine: decodes one byte per cycle and emits finished results.
module ebml_parse #(
  parameter int unsigned MAX_ID_BYTES   = 4,
  parameter int unsigned MAX_SIZE_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  ebml_pkg::in_word_t word,
  output logic               push,
  output ebml_pkg::result_t  res
);

  localparam logic [63:0] Max63 = {1'b0, {63{1'b1}}};

  ebml_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       left_r, left_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [2:0]       idlen_r, idlen_nxt;
  logic [55:0]      size_r, size_nxt;
  logic [3:0]       szlen_r, szlen_nxt;
  logic [62:0]      start_r, start_nxt;

  logic [7:0]  b;
  logic [3:0]  lz;
  logic        finish;
  logic [63:0] sum;

  assign b  = word.stream_byte;
  assign lz = ebml_pkg::lead_zeros(b);

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    id_nxt    = id_r;
    idlen_nxt = idlen_r;
    size_nxt  = size_r;
    szlen_nxt = szlen_r;
    start_nxt = start_r;
    finish    = 1'b0;
    sum       = '0;
    push      = 1'b0;
    res       = '0;
    res.status = ebml_pkg::ST_OK;

    if (go) begin
      case (phase_r)
        ebml_pkg::PH_ID_LEAD: begin
          start_nxt = word.start_offset;
          if (lz >= 4'(MAX_ID_BYTES)) begin
            push             = 1'b1;
            res.element_id   = 32'(b);
            res.header_start = word.start_offset;
            res.element_end  = word.start_offset;
            res.status       = ebml_pkg::ST_BAD_ID;
          end else begin
            id_nxt    = 32'(b);
            idlen_nxt = lz[2:0] + 3'd1;
            left_nxt  = lz;
            phase_nxt = (lz != 4'd0) ? ebml_pkg::PH_ID_REST : ebml_pkg::PH_SIZE_LEAD;
          end
        end
        ebml_pkg::PH_ID_REST: begin
          id_nxt = {id_r[23:0], b};
          if (left_r <= 4'd1) begin
            left_nxt  = 4'd0;
            phase_nxt = ebml_pkg::PH_SIZE_LEAD;
          end else begin
            left_nxt = left_r - 4'd1;
          end
        end
        ebml_pkg::PH_SIZE_LEAD: begin
          if (lz >= 4'(MAX_SIZE_BYTES)) begin
            push             = 1'b1;
            res.element_id   = id_r;
            res.id_length    = idlen_r;
            res.header_start = start_r;
            res.element_end  = start_r;
            res.status       = ebml_pkg::ST_BAD_SIZE;
            phase_nxt        = ebml_pkg::PH_ID_LEAD;
            left_nxt         = 4'd0;
          end else begin
            szlen_nxt = lz + 4'd1;
            // strip the length marker
            size_nxt  = 56'(b & (8'h7f >> lz));
            left_nxt  = lz;
            if (lz == 4'd0) finish = 1'b1;
            else phase_nxt = ebml_pkg::PH_SIZE_REST;
          end
        end
        ebml_pkg::PH_SIZE_REST: begin
          size_nxt = {size_r[47:0], b};
          if (left_r <= 4'd1) finish = 1'b1;
          else left_nxt = left_r - 4'd1;
        end
        default: begin
          phase_nxt = ebml_pkg::PH_ID_LEAD;
        end
      endcase

      if (finish) begin
        sum = {1'b0, start_r} + 64'(idlen_r) + 64'(szlen_nxt) + 64'(size_nxt);
        push             = 1'b1;
        res.element_id   = id_r;
        res.id_length    = idlen_r;
        res.size_value   = size_nxt;
        res.size_length  = szlen_nxt;
        res.header_start = start_r;
        if (sum[63]) begin
          res.element_end = Max63[62:0];
          res.status      = ebml_pkg::ST_OVERFLOW;
        end else begin
          res.element_end = sum[62:0];
        end
        phase_nxt = ebml_pkg::PH_ID_LEAD;
        left_nxt  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ebml_pkg::PH_ID_LEAD;
      left_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    idlen_r <= idlen_nxt;
    size_r  <= size_nxt;
    szlen_r <= szlen_nxt;
    start_r <= start_nxt;
  end

endmodule

>>> rtl/core/ebml_out_buf.sv
// Two-entry result buffer: decouples the parser from a stalled consumer.
module ebml_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ebml_pkg::result_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output ebml_pkg::result_t out_word
);

  ebml_pkg::result_t buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = buf_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= push_word;
  end

endmodule

>>> rtl/core/ebml_element_header_parser.sv
// EBML element header parser. Takes one header byte per cycle; the first byte
// of each header also carries its absolute offset. The ID (1 to MAX_ID_BYTES
// bytes, marker kept) and the size (1 to MAX_SIZE_BYTES bytes, marker removed)
// are collected, and after the last size byte one word reports ID, lengths,
// size, start and end offset (status 3 and a saturated end on overflow). A bad
// lead byte ends the header at once with status 1 or 2. Throughput is one byte
// per cycle while the result buffer is not full, set by the combinational
// decode between the input register and the two-entry result buffer; a result
// is written into the buffer when its last byte leaves the input register. A
// pending result does not stop input while the buffer has room.
module ebml_element_header_parser #(
  parameter int unsigned MAX_ID_BYTES   = 4,
  parameter int unsigned MAX_SIZE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic [62:0] in_start_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_element_id,
  output logic [2:0]  out_id_length,
  output logic [55:0] out_size_value,
  output logic [3:0]  out_size_length,
  output logic [62:0] out_header_start,
  output logic [62:0] out_element_end,
  output logic [1:0]  out_status
);

  ebml_pkg::in_word_t in_word, word;
  ebml_pkg::result_t  res, out_word;
  logic word_valid, take, push, full;

  assign in_word.stream_byte  = in_stream_byte;
  assign in_word.start_offset = in_start_offset;

  // advance the input register whenever the buffer can take a result
  assign take = word_valid && !full;

  ebml_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  ebml_parse #(
    .MAX_ID_BYTES   (MAX_ID_BYTES),
    .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (take),
    .word  (word),
    .push  (push),
    .res   (res)
  );

  ebml_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_element_id   = out_word.element_id;
  assign out_id_length    = out_word.id_length;
  assign out_size_value   = out_word.size_value;
  assign out_size_length  = out_word.size_length;
  assign out_header_start = out_word.header_start;
  assign out_element_end  = out_word.element_end;
  assign out_status       = out_word.status;

endmodule

>>> tb/ebml_element_header_parser_test.sv
`timescale 1ns / 100ps
// Testbench for the EBML element header parser: directed and random byte streams in, decoded headers checked.

module ebml_element_header_parser_test;

  localparam logic [62:0] OFFSET_MAX = {63{1'b1}};
  localparam int ID_BYTES_MAX   = 4;
  localparam int SIZE_BYTES_MAX = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_stream_byte;
  logic [62:0] in_start_offset;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_element_id;
  logic [2:0]  out_id_length;
  logic [55:0] out_size_value;
  logic [3:0]  out_size_length;
  logic [62:0] out_header_start;
  logic [62:0] out_element_end;
  logic [1:0]  out_status;

  logic hold_off;
  bit   quiet;
  int   words_sent;

  class header_scoreboard;
    ebml_pkg::phase_t  phase_q;
    logic [3:0]        left_q;
    logic [31:0]       id_q;
    logic [2:0]        id_len_q;
    logic [55:0]       size_q;
    logic [3:0]        size_len_q;
    logic [62:0]       start_q;
    ebml_pkg::result_t pending_headers[$];
    int                failures;

    function new();
      phase_q    = ebml_pkg::PH_ID_LEAD;
      left_q     = '0;
      id_q       = '0;
      id_len_q   = '0;
      size_q     = '0;
      size_len_q = '0;
      start_q    = '0;
      failures   = 0;
    endfunction

    function int count_lead_zeros(logic [7:0] b);
      int n;
      n = 0;
      for (int i = 7; i >= 0 && !b[i]; i--) n++;
      return n;
    endfunction

    // Sum offsets in 64 bits so the carry into bit 63 marks an overflow.
    function void close_header();
      logic [63:0]       sum;
      ebml_pkg::result_t r;
      sum = {1'b0, start_q} + 64'(id_len_q) + 64'(size_len_q) + 64'(size_q);
      r.element_id   = id_q;
      r.id_length    = id_len_q;
      r.size_value   = size_q;
      r.size_length  = size_len_q;
      r.header_start = start_q;
      r.element_end  = sum[62:0];
      r.status       = ebml_pkg::ST_OK;
      if (sum[63]) begin
        r.element_end = OFFSET_MAX;
        r.status      = ebml_pkg::ST_OVERFLOW;
      end
      pending_headers.push_back(r);
      phase_q = ebml_pkg::PH_ID_LEAD;
      left_q  = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic [62:0] off);
      int                lz;
      ebml_pkg::result_t r;
      case (phase_q)
        ebml_pkg::PH_ID_LEAD: begin
          start_q = off;
          lz = count_lead_zeros(b);
          if (lz >= ID_BYTES_MAX) begin
            r.element_id   = {24'd0, b};
            r.id_length    = '0;
            r.size_value   = '0;
            r.size_length  = '0;
            r.header_start = off;
            r.element_end  = off;
            r.status       = ebml_pkg::ST_BAD_ID;
            pending_headers.push_back(r);
          end else begin
            id_q     = {24'd0, b};
            id_len_q = 3'(lz + 1);
            left_q   = 4'(lz);
            phase_q  = (lz != 0) ? ebml_pkg::PH_ID_REST : ebml_pkg::PH_SIZE_LEAD;
          end
        end
        ebml_pkg::PH_ID_REST: begin
          id_q = {id_q[23:0], b};
          if (left_q <= 1) begin
            left_q  = '0;
            phase_q = ebml_pkg::PH_SIZE_LEAD;
          end else begin
            left_q--;
          end
        end
        ebml_pkg::PH_SIZE_LEAD: begin
          lz = count_lead_zeros(b);
          if (lz >= SIZE_BYTES_MAX) begin
            r.element_id   = id_q;
            r.id_length    = id_len_q;
            r.size_value   = '0;
            r.size_length  = '0;
            r.header_start = start_q;
            r.element_end  = start_q;
            r.status       = ebml_pkg::ST_BAD_SIZE;
            pending_headers.push_back(r);
            phase_q = ebml_pkg::PH_ID_LEAD;
            left_q  = '0;
          end else begin
            size_len_q = 4'(lz + 1);
            size_q     = 56'(b & (8'h7F >> lz));
            left_q     = 4'(lz);
            if (lz == 0) close_header();
            else phase_q = ebml_pkg::PH_SIZE_REST;
          end
        end
        ebml_pkg::PH_SIZE_REST: begin
          size_q = {size_q[47:0], b};
          if (left_q <= 1) close_header();
          else left_q--;
        end
        default: begin
          phase_q = ebml_pkg::PH_ID_LEAD;
        end
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
      failures++;
    endtask

    task check_result(ebml_pkg::result_t got);
      ebml_pkg::result_t want;
      if (pending_headers.size() == 0) begin
        report("unexpected word, element_id", 64'(got.element_id), 64'd0);
        return;
      end
      want = pending_headers.pop_front();
      if (got.element_id !== want.element_id)
        report("element_id", 64'(got.element_id), 64'(want.element_id));
      if (got.id_length !== want.id_length)
        report("id_length", 64'(got.id_length), 64'(want.id_length));
      if (got.size_value !== want.size_value)
        report("size_value", 64'(got.size_value), 64'(want.size_value));
      if (got.size_length !== want.size_length)
        report("size_length", 64'(got.size_length), 64'(want.size_length));
      if (got.header_start !== want.header_start)
        report("header_start", 64'(got.header_start), 64'(want.header_start));
      if (got.element_end !== want.element_end)
        report("element_end", 64'(got.element_end), 64'(want.element_end));
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  header_scoreboard tracker = new();

  ebml_element_header_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .in_start_offset  (in_start_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_element_id   (out_element_id),
    .out_id_length    (out_id_length),
    .out_size_value   (out_size_value),
    .out_size_length  (out_size_length),
    .out_header_start (out_header_start),
    .out_element_end  (out_element_end),
    .out_status       (out_status)
  );

  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [62:0] rand_offset();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[62:0];
  endfunction

  function logic [62:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return OFFSET_MAX - 63'($urandom_range(0, 600));
    if (r < 30) return 63'($urandom_range(0, 1000));
    return rand_offset();
  endfunction

  // Hold the word until accepted, then idle for a random gap.
  task automatic send_byte(input logic [7:0] b, input logic [62:0] off);
    int gap;
    in_valid        <= 1'b1;
    in_stream_byte  <= b;
    in_start_offset <= off;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, off);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Only the first byte's offset matters; randomize the rest.
  task automatic send_frame(input logic [7:0] seq[$], input logic [62:0] off);
    foreach (seq[i]) send_byte(seq[i], (i == 0) ? off : rand_offset());
  endtask

  task automatic send_random_header();
    logic [7:0]  seq[$];
    logic [62:0] off;
    int          lz;
    int          r;
    r   = $urandom_range(0, 99);
    off = pick_offset();
    if (r < 6) begin
      seq.push_back(8'($urandom_range(0, 15)));
    end else if (r < 10) begin
      seq.push_back(8'($urandom()));
    end else begin
      lz = $urandom_range(0, ID_BYTES_MAX - 1);
      seq.push_back((8'h80 >> lz) | (8'($urandom()) & (8'h7F >> lz)));
      repeat (lz) seq.push_back(8'($urandom()));
      if (r < 16) begin
        seq.push_back(8'h00);
      end else begin
        lz = $urandom_range(0, SIZE_BYTES_MAX - 1);
        if (r < 24) begin
          // unknown-size code: all value bits set
          seq.push_back(8'hFF >> lz);
          repeat (lz) seq.push_back(8'hFF);
        end else begin
          seq.push_back((8'h80 >> lz) | (8'($urandom()) & (8'h7F >> lz)));
          repeat (lz) seq.push_back(8'($urandom()));
        end
      end
    end
    send_frame(seq, off);
  endtask

  initial begin : stimulus
    logic [7:0] seq[$];
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_stream_byte  <= '0;
    in_start_offset <= '0;
    quiet      = 1'b0;
    words_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    seq = {8'h80, 8'h80};
    send_frame(seq, 63'd0);
    seq = {8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(seq, OFFSET_MAX);
    seq = {8'h00};
    send_frame(seq, OFFSET_MAX);
    seq = {8'h0F};
    send_frame(seq, rand_offset());
    seq = {8'hFF, 8'h00};
    send_frame(seq, rand_offset());
    // end lands exactly on the largest offset
    seq = {8'h40, 8'h00, 8'hFF};
    send_frame(seq, OFFSET_MAX - 63'd130);
    // one past the largest offset
    seq = {8'h81, 8'h81};
    send_frame(seq, OFFSET_MAX - 63'd2);

    while (words_sent < 420) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      send_random_header();
    end
    in_valid <= 1'b0;

    while (tracker.pending_headers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.failures == 0) $display("ebml_element_header_parser regression: pass");
    else $display("ebml_element_header_parser regression: fail");
    $finish;
  end

  initial begin : result_sink
    int                stall;
    ebml_pkg::result_t got;
    stall = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.element_id   = out_element_id;
        got.id_length    = out_id_length;
        got.size_value   = out_size_value;
        got.size_length  = out_size_length;
        got.header_start = out_header_start;
        got.element_end  = out_element_end;
        got.status       = ebml_pkg::status_t'(out_status);
        tracker.check_result(got);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Block the result side long enough for the input to back up.
  initial begin : backpressure
    hold_off <= 1'b0;
    while (words_sent < 120) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("ebml_element_header_parser regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ebml_pkg.sv
rtl/core/ebml_in_stage.sv
rtl/core/ebml_parse.sv
rtl/core/ebml_out_buf.sv
rtl/core/ebml_element_header_parser.sv
tb/ebml_element_header_parser_test.sv
